@@ sv/iodc_pkg.sv @@
// ----------------------------------------------------------------------------
// iodc_pkg
// Shared widths, reset values, codes and types of the batch descriptor checker.
// ----------------------------------------------------------------------------
package iodc_pkg;

  localparam int unsigned BLK_W      = 17;
  localparam int unsigned TOT_W      = 48;
  localparam int unsigned CHUNK_W    = 32;
  localparam int unsigned OFS_W      = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ALN_W      = CNT_W + 1;
  localparam int unsigned PROD_W     = TOT_W + BLK_W;
  localparam int unsigned BYTES_W    = 31;
  localparam int unsigned ITEMS_W    = 7;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned DIV_CNT_W  = $clog2(OFS_W);
  localparam int unsigned PAGE_BITS  = 12;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned MAX_BYTES_DEF = 1073741824;

  localparam logic [BLK_W-1:0]   BLK_BYTES_RST = BLK_W'(512);
  localparam logic [CHUNK_W-1:0] DMA_CHUNK_RST = CHUNK_W'(4096);

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_SETUP      = 3'd1,
    STAT_BAD_ITEM   = 3'd2,
    STAT_BYTE_LIMIT = 3'd3,
    STAT_RANGE      = 3'd4,
    STAT_COUNT      = 3'd5,
    STAT_EARLIER    = 3'd6
  } iodc_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLK_BYTES          = 3'd0,
    CFG_NS_BLOCKS          = 3'd1,
    CFG_DMA_CHUNK          = 3'd2,
    CFG_STOP_REQUESTED     = 3'd3,
    CFG_INTAKE_CLOSED      = 3'd4,
    CFG_DEVICE_QUARANTINED = 3'd5
  } iodc_cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_EVAL,
    S_RANGE,
    S_DIV_OFS,
    S_DIV_ALN,
    S_FINISH
  } iodc_state_e;

  typedef struct packed {
    logic [BLK_W-1:0]   blk_bytes;
    logic [TOT_W-1:0]   ns_blocks;
    logic [CHUNK_W-1:0] dma_chunk;
    logic               stop_requested;
    logic               intake_closed;
    logic               device_quarantined;
  } iodc_cfg_t;

  typedef struct packed {
    logic               buffer_present;
    logic [OFS_W-1:0]   byte_offset;
    logic [CNT_W-1:0]   byte_count;
    logic               last_item;
  } iodc_item_t;

  typedef struct packed {
    logic               start;
    logic [OFS_W-1:0]   dividend;
    logic [BLK_W-1:0]   divisor;
  } iodc_div_req_t;

  typedef struct packed {
    logic               done;
    logic [BLK_W-1:0]   remainder;
  } iodc_div_rsp_t;

  typedef struct packed {
    iodc_status_e       status;
    logic [CNT_W-1:0]   rounded_size;
    logic               batch_end;
    logic               batch_ok;
  } iodc_result_t;

endpackage

@@ sv/iodc_if.sv @@
// ----------------------------------------------------------------------------
// iodc channel interfaces
// Valid/ready channels for descriptor requests, results and register writes.
// ----------------------------------------------------------------------------
interface iodc_req_if import iodc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               buffer_present;
  logic [OFS_W-1:0]   byte_offset;
  logic [CNT_W-1:0]   byte_count;
  logic               last_item;

  modport source (output valid, buffer_present, byte_offset, byte_count, last_item,
                  input ready);
  modport sink (input valid, buffer_present, byte_offset, byte_count, last_item,
                output ready);
endinterface

interface iodc_rsp_if import iodc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    rounded_size;
  logic                batch_end;
  logic                batch_ok;

  modport source (output valid, status, rounded_size, batch_end, batch_ok,
                  input ready);
  modport sink (input valid, status, rounded_size, batch_end, batch_ok,
                output ready);
endinterface

interface iodc_cfg_if import iodc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/iodc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// iodc_cfg_regs
// Configuration register file written through the register write channel.
// ----------------------------------------------------------------------------
module iodc_cfg_regs import iodc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  iodc_cfg_if.sink   cfg_i,
  output iodc_cfg_t  cfg_o
);

  iodc_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BLK_BYTES:          cfg_d.blk_bytes          = cfg_i.data[BLK_W-1:0];
        CFG_NS_BLOCKS:          cfg_d.ns_blocks          = cfg_i.data[TOT_W-1:0];
        CFG_DMA_CHUNK:          cfg_d.dma_chunk          = cfg_i.data[CHUNK_W-1:0];
        CFG_STOP_REQUESTED:     cfg_d.stop_requested     = cfg_i.data[0];
        CFG_INTAKE_CLOSED:      cfg_d.intake_closed      = cfg_i.data[0];
        CFG_DEVICE_QUARANTINED: cfg_d.device_quarantined = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blk_bytes          <= BLK_BYTES_RST;
      cfg_q.ns_blocks          <= '0;
      cfg_q.dma_chunk          <= DMA_CHUNK_RST;
      cfg_q.stop_requested     <= 1'b0;
      cfg_q.intake_closed      <= 1'b0;
      cfg_q.device_quarantined <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/iodc_rem_unit.sv @@
// ----------------------------------------------------------------------------
// iodc_rem_unit
// Shared restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module iodc_rem_unit import iodc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  iodc_div_req_t div_req_i,
  output iodc_div_rsp_t div_rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFS_W-1:0]     dvd_q, dvd_d;
  logic [BLK_W-1:0]     dsr_q, dsr_d;
  logic [BLK_W-1:0]     rem_q, rem_d;
  logic [BLK_W:0]       trial;

  assign div_rsp_o.done      = done_q;
  assign div_rsp_o.remainder = rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[OFS_W-1]};
    if (div_req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = div_req_i.dividend;
      dsr_d  = div_req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = BLK_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[BLK_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

endmodule

@@ sv/iodc_seq.sv @@
// ----------------------------------------------------------------------------
// iodc_seq
// Check sequencer: batch state, priority checks and remainder unit control.
// ----------------------------------------------------------------------------
module iodc_seq import iodc_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  iodc_cfg_t     cfg_i,
  input  logic          item_valid_i,
  input  iodc_item_t    item_i,
  output logic          item_ready_o,
  output iodc_div_req_t div_req_o,
  input  iodc_div_rsp_t div_rsp_i,
  input  logic          out_free_i,
  output logic          push_o,
  output iodc_result_t  result_o
);

  iodc_state_e         state_q, state_d;
  iodc_status_e        status_q, status_d;
  iodc_item_t          item_q, item_d;
  logic [ALN_W-1:0]    aligned_q, aligned_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [OFS_W-1:0]    ns_q, ns_d;
  logic [BYTES_W-1:0]  byte_total_q, byte_total_d;
  logic [ITEMS_W-1:0]  item_count_q, item_count_d;
  logic                failed_q, failed_d;

  logic                first;
  logic                setup_bad;
  logic                fail_next;
  logic [CNT_W-1:0]    byte_room;
  logic [ALN_W-1:0]    round_sum;

  assign first     = (item_count_q == '0);
  assign setup_bad = cfg_i.stop_requested || cfg_i.intake_closed ||
                     cfg_i.device_quarantined || (cfg_i.blk_bytes == '0) ||
                     (cfg_i.dma_chunk == '0) || (cfg_i.dma_chunk[PAGE_BITS-1:0] != '0) ||
                     (cfg_i.ns_blocks == '0) || prod_q[PROD_W-1];
  assign fail_next = failed_q || (status_q != STAT_OK);
  assign byte_room = CNT_W'(MAX_BYTES) - {1'b0, byte_total_q};
  assign round_sum = {1'b0, item_i.byte_count} + ALN_W'((1 << PAGE_BITS) - 1);

  assign result_o.status       = status_q;
  assign result_o.rounded_size = aligned_q[CNT_W-1:0];
  assign result_o.batch_end    = item_q.last_item;
  assign result_o.batch_ok     = item_q.last_item && !fail_next;

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    item_d       = item_q;
    aligned_d    = aligned_q;
    prod_d       = prod_q;
    ns_d         = ns_q;
    byte_total_d = byte_total_q;
    item_count_d = item_count_q;
    failed_d     = failed_q;
    item_ready_o = 1'b0;
    push_o       = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = item_q.byte_offset;
    div_req_o.divisor  = cfg_i.blk_bytes;

    case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d    = item_i;
          aligned_d = {round_sum[ALN_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
          state_d   = S_PRE;
        end
      end
      S_PRE: begin
        prod_d  = PROD_W'(cfg_i.ns_blocks) * PROD_W'(cfg_i.blk_bytes);
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_FINISH;
        if (first && !failed_q) begin
          ns_d = setup_bad ? '0 : prod_q[OFS_W-1:0];
        end
        if (failed_q) begin
          status_d = STAT_EARLIER;
        end else if (first && setup_bad) begin
          status_d = STAT_SETUP;
        end else if (item_count_q >= ITEMS_W'(MAX_ITEMS)) begin
          status_d = STAT_COUNT;
        end else if (!item_q.buffer_present || (item_q.byte_count == '0) ||
                     (item_q.byte_count > cfg_i.dma_chunk)) begin
          status_d = STAT_BAD_ITEM;
        end else if (aligned_q > {1'b0, byte_room}) begin
          status_d = STAT_BYTE_LIMIT;
        end else begin
          byte_total_d = byte_total_q + aligned_q[BYTES_W-1:0];
          status_d     = STAT_OK;
          state_d      = S_RANGE;
        end
      end
      S_RANGE: begin
        if ((cfg_i.blk_bytes == '0) || (aligned_q > {1'b0, cfg_i.dma_chunk}) ||
            (item_q.byte_offset > ns_q) ||
            (OFS_W'(aligned_q) > (ns_q - item_q.byte_offset))) begin
          status_d = STAT_RANGE;
          state_d  = S_FINISH;
        end else begin
          div_req_o.start = 1'b1;
          state_d         = S_DIV_OFS;
        end
      end
      S_DIV_OFS: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.remainder != '0) begin
            status_d = STAT_RANGE;
            state_d  = S_FINISH;
          end else begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = OFS_W'(aligned_q);
            state_d            = S_DIV_ALN;
          end
        end
      end
      S_DIV_ALN: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.remainder != '0) begin
            status_d = STAT_RANGE;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
          if (item_q.last_item) begin
            byte_total_d = '0;
            item_count_d = '0;
            failed_d     = 1'b0;
            ns_d         = '0;
          end else begin
            failed_d = fail_next;
            if (item_count_q != '1) begin
              item_count_d = item_count_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      status_q     <= STAT_OK;
      ns_q         <= '0;
      byte_total_q <= '0;
      item_count_q <= '0;
      failed_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      status_q     <= status_d;
      ns_q         <= ns_d;
      byte_total_q <= byte_total_d;
      item_count_q <= item_count_d;
      failed_q     <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    aligned_q <= aligned_d;
    prod_q    <= prod_d;
  end

endmodule

@@ sv/io_batch_descriptor_checker_top.sv @@
// ----------------------------------------------------------------------------
// io_batch_descriptor_checker_top
// Checks storage transfer descriptors of a batch against setup and limits.
// ----------------------------------------------------------------------------
// usage:
//   cfg_i  register writes (index, data), always ready; write only while idle
//   req_i  one descriptor per request; ready only while no request is in work
//   rsp_o  one result per request, held in an output register until taken
// flow:
//   an early check failure or a failed range compare ends the request; an
//   unaligned offset ends it after the first of two 64-step passes of the
//   shared remainder unit, which both run in the long case; the next request
//   is taken once the result is registered
// reset:
//   registers return to block size 512, dma chunk 4096, all else zero, and
//   the batch state (byte total, item count, failure flag, capacity) clears
// stall:
//   a waiting result does not block intake; a new request is taken and
//   worked, and its result waits until the output register is free
// ----------------------------------------------------------------------------
module io_batch_descriptor_checker_top import iodc_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iodc_cfg_if.sink     cfg_i,
  iodc_req_if.sink     req_i,
  iodc_rsp_if.source   rsp_o
);

  iodc_cfg_t     cfg;
  iodc_item_t    item;
  iodc_div_req_t div_req;
  iodc_div_rsp_t div_rsp;
  iodc_result_t  result;
  iodc_result_t  rsp_q;
  logic          rsp_valid_q;
  logic          out_free;
  logic          push;

  assign item.buffer_present = req_i.buffer_present;
  assign item.byte_offset    = req_i.byte_offset;
  assign item.byte_count     = req_i.byte_count;
  assign item.last_item      = req_i.last_item;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  iodc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  iodc_rem_unit u_rem_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  iodc_seq #(
    .MAX_ITEMS (MAX_ITEMS),
    .MAX_BYTES (MAX_BYTES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (req_i.valid),
    .item_i       (item),
    .item_ready_o (req_i.ready),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_free_i   (out_free),
    .push_o       (push),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      rsp_q <= result;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.rounded_size = rsp_q.rounded_size;
  assign rsp_o.batch_end    = rsp_q.batch_end;
  assign rsp_o.batch_ok     = rsp_q.batch_ok;

  // a request in work blocks intake until its result is pushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in work");

  // a batch verdict of ok only closes a batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.batch_ok) |-> (rsp_o.batch_end && (rsp_o.status == STAT_OK)))
    else $error("batch ok on a result that is not a passing batch end");

  // a result is only pushed into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result overwrote a pending response");

  // the remainder unit finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> !req_i.ready)
    else $error("remainder finished while idle");

endmodule
